// File: hdl/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared widths, constants and types of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int CAP_W   = 13;
    localparam int POINT_W = 21;
    localparam int PEND_W  = 2;

    // Result queue: depth and derived pointer / count widths
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    // Worst-case number of units that one byte pushes
    localparam int MAX_PUSH    = 2;

    // Code point limits
    localparam logic [POINT_W-1:0] MAX_POINT  = 21'h10FFFF;
    localparam logic [POINT_W-1:0] SURR_FIRST = 21'h00D800;
    localparam logic [POINT_W-1:0] SURR_LAST  = 21'h00DFFF;
    localparam logic [POINT_W-1:0] SUPP_BASE  = 21'h010000;

    // Surrogate unit prefixes
    localparam logic [UNIT_W-1:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0] LOW_SURR_BASE  = 16'hDC00;

    // Byte class patterns
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

    // Reset value of the capacity register
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd65;

    // One result item
    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              string_end;
        logic              run_last;
    } result_t;

    // Units that the decoder hands to the result queue at once
    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// File: hdl/u2u_decode.sv
// ----------------------------------------------------------------------------
// u2u_decode
// Decodes one registered UTF-8 byte per cycle while advance is high, against
// the sequence state, and produces zero, one or two UTF-16 units for the result queue.
// ----------------------------------------------------------------------------
module u2u_decode (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [u2u_pkg::CAP_W-1:0]  cfg_wr_data,
    input  logic                       advance,
    input  logic [u2u_pkg::BYTE_W-1:0] data_byte,
    output u2u_pkg::push_t             push
);

    logic [u2u_pkg::CAP_W-1:0]   cap_reg;
    logic [u2u_pkg::POINT_W-1:0] point_reg, point_next;
    logic [u2u_pkg::PEND_W-1:0]  pend_reg, pend_next;
    logic [u2u_pkg::CAP_W-1:0]   units_reg, units_next;
    logic                        stop_reg, stop_next;

    logic [u2u_pkg::CAP_W-1:0]   cap_eff;
    logic [u2u_pkg::CAP_W:0]     units_plus1;
    logic [u2u_pkg::CAP_W:0]     units_plus2;
    logic                        is_cont;
    logic [u2u_pkg::POINT_W-1:0] acc;
    logic                        done;
    logic [u2u_pkg::POINT_W-1:0] done_point;
    logic                        bad_point;
    logic [u2u_pkg::POINT_W-1:0] offset;
    u2u_pkg::push_t              push_comb;

    // Zero capacity behaves as room for the terminator only
    assign cap_eff     = (cap_reg == '0) ? u2u_pkg::CAP_W'(1) : cap_reg;
    assign units_plus1 = {1'b0, units_reg} + (u2u_pkg::CAP_W + 1)'(1);
    assign units_plus2 = {1'b0, units_reg} + (u2u_pkg::CAP_W + 1)'(2);
    assign is_cont     = (data_byte & u2u_pkg::CONT_MASK) == u2u_pkg::CONT_CODE;
    assign acc         = {point_reg[u2u_pkg::POINT_W-7:0], data_byte[5:0]};
    assign bad_point   = (done_point > u2u_pkg::MAX_POINT) ||
                         ((done_point >= u2u_pkg::SURR_FIRST) &&
                          (done_point <= u2u_pkg::SURR_LAST));
    assign offset      = done_point - u2u_pkg::SUPP_BASE;

    // Sequence tracking and unit generation
    always_comb begin
        point_next = point_reg;
        pend_next  = pend_reg;
        units_next = units_reg;
        stop_next  = stop_reg;
        done       = 1'b0;
        done_point = '0;
        push_comb  = '0;

        if (data_byte == '0) begin
            // Terminator: drop everything, emit the zero unit
            point_next                 = '0;
            pend_next                  = '0;
            units_next                 = '0;
            stop_next                  = 1'b0;
            push_comb.num              = 2'd1;
            push_comb.first.string_end = 1'b1;
        end else if (!stop_reg) begin
            if ((pend_reg != '0) && is_cont) begin
                pend_next = pend_reg - u2u_pkg::PEND_W'(1);
                if (pend_reg == u2u_pkg::PEND_W'(1)) begin
                    done       = 1'b1;
                    done_point = acc;
                    point_next = '0;
                end else begin
                    point_next = acc;
                end
            end else begin
                // Fresh lead byte; a broken sequence is dropped here
                pend_next  = '0;
                point_next = '0;
                if (data_byte[7] == 1'b0) begin
                    done       = 1'b1;
                    done_point = u2u_pkg::POINT_W'(data_byte);
                end else if ((data_byte & u2u_pkg::LEAD2_MASK) == u2u_pkg::LEAD2_CODE) begin
                    point_next = u2u_pkg::POINT_W'(data_byte[4:0]);
                    pend_next  = u2u_pkg::PEND_W'(1);
                end else if ((data_byte & u2u_pkg::LEAD3_MASK) == u2u_pkg::LEAD3_CODE) begin
                    point_next = u2u_pkg::POINT_W'(data_byte[3:0]);
                    pend_next  = u2u_pkg::PEND_W'(2);
                end else if ((data_byte & u2u_pkg::LEAD4_MASK) == u2u_pkg::LEAD4_CODE) begin
                    point_next = u2u_pkg::POINT_W'(data_byte[2:0]);
                    pend_next  = u2u_pkg::PEND_W'(3);
                end
            end

            // Emit a finished point if it is representable and fits
            if (done && !bad_point) begin
                if (units_plus1 >= {1'b0, cap_eff}) begin
                    stop_next = 1'b1;
                end else if (done_point >= u2u_pkg::SUPP_BASE) begin
                    if (units_plus2 >= {1'b0, cap_eff}) begin
                        stop_next = 1'b1;
                    end else begin
                        push_comb.num              = 2'd2;
                        push_comb.first.code_unit  = u2u_pkg::HIGH_SURR_BASE |
                                                     u2u_pkg::UNIT_W'(offset[19:10]);
                        push_comb.second.code_unit = u2u_pkg::LOW_SURR_BASE |
                                                     u2u_pkg::UNIT_W'(offset[9:0]);
                        units_next                 = units_plus2[u2u_pkg::CAP_W-1:0];
                    end
                end else begin
                    push_comb.num             = 2'd1;
                    push_comb.first.code_unit = done_point[u2u_pkg::UNIT_W-1:0];
                    units_next                = units_plus1[u2u_pkg::CAP_W-1:0];
                end
            end
        end

        // Mark the final unit of this byte
        push_comb.first.run_last  = (push_comb.num == 2'd1);
        push_comb.second.run_last = 1'b1;
    end

    // Hand units to the queue only on the cycle the byte is consumed
    always_comb begin
        push = push_comb;
        if (!advance) begin
            push.num = 2'd0;
        end
    end

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= u2u_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Sequence state: advance on each consumed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_reg <= '0;
            pend_reg  <= '0;
            units_reg <= '0;
            stop_reg  <= 1'b0;
        end else if (advance) begin
            point_reg <= point_next;
            pend_reg  <= pend_next;
            units_reg <= units_next;
            stop_reg  <= stop_next;
        end
    end

`ifndef SYNTHESIS
    // A zero byte leaves the string state cleared
    a_zero_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (data_byte == '0)) |=>
            ((units_reg == '0) && (pend_reg == '0) && !stop_reg && (point_reg == '0)))
        else $error("string state not cleared after terminator");

    // A pair always opens with a high surrogate
    a_pair_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.num == 2'd2) |->
            ((push.first.code_unit[15:10] == 6'b110110) &&
             (push.second.code_unit[15:10] == 6'b110111)))
        else $error("surrogate pair malformed");

    // Once stopped, only the terminator may produce a unit
    a_stopped_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && stop_reg && (data_byte != '0)) |-> (push.num == 2'd0))
        else $error("unit emitted while output stopped");
`endif

endmodule

// File: hdl/u2u_out_queue.sv
// ----------------------------------------------------------------------------
// u2u_out_queue
// Small result queue: takes up to two units per cycle, gives one per cycle
// to the result channel while it is ready.
// ----------------------------------------------------------------------------
module u2u_out_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  u2u_pkg::push_t              push,
    input  logic                        pop,
    output logic                        not_empty,
    output logic                        has_room,
    output u2u_pkg::result_t            head
);

    u2u_pkg::result_t              entry_reg [u2u_pkg::QUEUE_DEPTH];
    logic [u2u_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [u2u_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [u2u_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic [u2u_pkg::QPTR_W-1:0]    wr_ptr_plus1;

    assign not_empty    = (count_reg != '0);
    assign has_room     = (count_reg <= u2u_pkg::QCNT_W'(u2u_pkg::QUEUE_DEPTH -
                                                         u2u_pkg::MAX_PUSH));
    assign head         = entry_reg[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + u2u_pkg::QPTR_W'(1);

    // Pointer and count bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg + u2u_pkg::QPTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + u2u_pkg::QPTR_W'(pop);
        count_next  = count_reg + u2u_pkg::QCNT_W'(push.num) - u2u_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed units
    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

`ifndef SYNTHESIS
    // Never hold more than the queue depth
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= u2u_pkg::QCNT_W'(u2u_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // Units only arrive when room for a pair was advertised
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.num != 2'd0) |-> has_room)
        else $error("push without room");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("result queue underflow");
`endif

endmodule

// File: hdl/utf8_to_utf16_transcoder_core.sv
// An accepted byte is held in the byte register, then decoded into the result queue,
// whose head drives m_valid. Bytes flow one per cycle while the queue has room for a pair.
// The four-entry result queue absorbs pairs, and the byte register stalls only while
// fewer than two queue slots are free.
// Reset (aresetn low, synchronous) clears the string state, empties the queue and
// restores the capacity register to 65 units.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// Streams UTF-8 bytes in and UTF-16 code units out, with destination
// capacity limiting and string termination.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [u2u_pkg::CAP_W-1:0]    cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [u2u_pkg::BYTE_W-1:0]   s_data_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [u2u_pkg::UNIT_W-1:0]   m_code_unit,
    output logic                         m_string_end,
    output logic                         m_run_last
);

    logic                        byte_valid_reg;
    logic [u2u_pkg::BYTE_W-1:0]  byte_reg;
    logic                        advance;
    logic                        pop;
    logic                        q_not_empty;
    logic                        q_has_room;
    u2u_pkg::push_t              push;
    u2u_pkg::result_t            head;

    // Consume the held byte when the queue can take a pair
    assign advance = byte_valid_reg && q_has_room;
    assign s_ready = !byte_valid_reg || advance;
    assign pop     = m_valid && m_ready;

    // Input register: hold one request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            byte_valid_reg <= 1'b1;
        end else if (advance) begin
            byte_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_data_byte;
        end
    end

    u2u_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .data_byte   (byte_reg),
        .push        (push)
    );

    u2u_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (pop),
        .not_empty (q_not_empty),
        .has_room  (q_has_room),
        .head      (head)
    );

    // Result channel
    assign m_valid      = q_not_empty;
    assign m_code_unit  = head.code_unit;
    assign m_string_end = head.string_end;
    assign m_run_last   = head.run_last;

endmodule

// File: tb/sv/tb_utf8_to_utf16_transcoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_transcoder_core
// Streams UTF-8 strings into the transcoder with random gaps on both sides.
// An in-bench decoder builds the expected UTF-16 units for every accepted
// byte, and a checker compares each unit that leaves the block, field by field.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_transcoder_core;

    localparam int RUN_LIMIT     = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 48;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_BYTES   = 20;

    // Byte that closes a string
    localparam logic [u2u_pkg::BYTE_W-1:0] NUL_BYTE = 8'h00;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [u2u_pkg::CAP_W-1:0]    cfg_wr_data;
    logic                         s_valid;
    logic                         s_ready;
    logic [u2u_pkg::BYTE_W-1:0]   s_data_byte;
    logic                         m_valid;
    logic                         m_ready;
    logic [u2u_pkg::UNIT_W-1:0]   m_code_unit;
    logic                         m_string_end;
    logic                         m_run_last;

    // Decoder state mirrored from the block
    logic [u2u_pkg::CAP_W-1:0]    cap_reg = u2u_pkg::CAP_RESET;
    logic [u2u_pkg::POINT_W-1:0]  acc_point = '0;
    logic [u2u_pkg::PEND_W-1:0]   cont_left = '0;
    logic [u2u_pkg::CAP_W-1:0]    units_out = '0;
    logic                         out_halted = 1'b0;
    u2u_pkg::result_t             expected_units[$];

    // Handshake pacing
    bit                  tx_gaps_on = 1'b1;
    bit                  rx_gaps_on = 1'b1;
    bit                  long_hold_req = 1'b0;

    // Bookkeeping
    int                  mismatches = 0;
    int                  live_bytes = 0;
    int                  sent_bytes = 0;
    int                  strings_done = 0;
    int                  pairs_seen = 0;
    int                  units_checked = 0;
    int                  cap_writes = 0;
    int                  input_stall_cycles = 0;
    int                  watch_cycles;
    u2u_pkg::result_t    got_unit;
    u2u_pkg::result_t    want_unit;

    utf8_to_utf16_transcoder_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_unit  (m_code_unit),
        .m_string_end (m_string_end),
        .m_run_last   (m_run_last)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder
    // ------------------------------------------------------------------

    function automatic void queue_unit(input logic [u2u_pkg::UNIT_W-1:0] unit,
                                       input logic is_end);
        u2u_pkg::result_t r;
        r.code_unit  = unit;
        r.string_end = is_end;
        r.run_last   = 1'b0;
        expected_units.push_back(r);
    endfunction

    // Emit a finished code point, or drop it, or stop the string when full
    function automatic void emit_point(input logic [u2u_pkg::POINT_W-1:0] cp);
        int                          room;
        logic [u2u_pkg::POINT_W-1:0] off;
        room = (cap_reg == 0) ? 1 : int'(cap_reg);
        if (cp > u2u_pkg::MAX_POINT ||
            (cp >= u2u_pkg::SURR_FIRST && cp <= u2u_pkg::SURR_LAST))
            return;
        if (int'(units_out) + 1 >= room) begin
            out_halted = 1'b1;
            return;
        end
        if (cp >= u2u_pkg::SUPP_BASE) begin
            if (int'(units_out) + 2 >= room) begin
                out_halted = 1'b1;
                return;
            end
            off = cp - u2u_pkg::SUPP_BASE;
            queue_unit(u2u_pkg::HIGH_SURR_BASE | {6'd0, off[19:10]}, 1'b0);
            queue_unit(u2u_pkg::LOW_SURR_BASE | {6'd0, off[9:0]}, 1'b0);
            units_out = units_out + u2u_pkg::CAP_W'(2);
            pairs_seen++;
        end else begin
            queue_unit(cp[u2u_pkg::UNIT_W-1:0], 1'b0);
            units_out = units_out + u2u_pkg::CAP_W'(1);
        end
    endfunction

    // Advance the decoder by one byte; returns 0 when the byte is ignored
    function automatic bit decode_byte(input logic [u2u_pkg::BYTE_W-1:0] c);
        int               before_n;
        bit               live;
        u2u_pkg::result_t tail;
        before_n = expected_units.size();
        live     = (c == NUL_BYTE) || !out_halted;
        if (c == NUL_BYTE) begin
            queue_unit('0, 1'b1);
            acc_point  = '0;
            cont_left  = '0;
            units_out  = '0;
            out_halted = 1'b0;
            strings_done++;
        end else if (!out_halted) begin
            if (cont_left != 0 && (c & u2u_pkg::CONT_MASK) == u2u_pkg::CONT_CODE) begin
                acc_point = {acc_point[u2u_pkg::POINT_W-7:0], c[5:0]};
                cont_left = cont_left - u2u_pkg::PEND_W'(1);
                if (cont_left == 0) begin
                    emit_point(acc_point);
                    acc_point = '0;
                end
            end else begin
                // drop any partial sequence and treat the byte as a lead
                cont_left = '0;
                acc_point = '0;
                if (c < u2u_pkg::CONT_CODE) begin
                    emit_point({13'd0, c});
                end else if ((c & u2u_pkg::LEAD2_MASK) == u2u_pkg::LEAD2_CODE) begin
                    acc_point = {16'd0, c[4:0]};
                    cont_left = 2'd1;
                end else if ((c & u2u_pkg::LEAD3_MASK) == u2u_pkg::LEAD3_CODE) begin
                    acc_point = {17'd0, c[3:0]};
                    cont_left = 2'd2;
                end else if ((c & u2u_pkg::LEAD4_MASK) == u2u_pkg::LEAD4_CODE) begin
                    acc_point = {18'd0, c[2:0]};
                    cont_left = 2'd3;
                end
            end
        end
        // flag the final unit of this byte
        if (expected_units.size() > before_n) begin
            tail = expected_units.pop_back();
            tail.run_last = 1'b1;
            expected_units.push_back(tail);
        end
        return live;
    endfunction

    // ------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------

    task automatic send_byte(input logic [u2u_pkg::BYTE_W-1:0] b);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sent_bytes++;
        if (decode_byte(b))
            live_bytes++;
    endtask

    // Send the first 'keep' bytes of the 'len'-byte encoding of cp
    task automatic send_point(input logic [u2u_pkg::POINT_W-1:0] cp, input int len,
                              input int keep);
        logic [u2u_pkg::BYTE_W-1:0] seq [4];
        case (len)
            1: seq[0] = {1'b0, cp[6:0]};
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
            send_byte(seq[i]);
    endtask

    // Drop valid, wait for every expected unit, then let the pipeline settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_units.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [u2u_pkg::CAP_W-1:0] units);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= units;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cap_reg = units;
        cap_writes++;
    endtask

    task automatic send_random_string();
        int                          symbols;
        int                          pick;
        int                          len;
        logic [u2u_pkg::POINT_W-1:0] cp;
        symbols = $urandom_range(1, 30);
        repeat (symbols) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_byte(u2u_pkg::BYTE_W'($urandom_range(1, 127)));
            end else if (pick < 85) begin
                len = $urandom_range(2, 4);
                case (len)
                    2: cp = u2u_pkg::POINT_W'($urandom_range(0, 'h7FF));
                    3: cp = u2u_pkg::POINT_W'($urandom_range(0, 'hFFFF));
                    default: cp = ($urandom_range(0, 3) != 0) ?
                                  u2u_pkg::POINT_W'($urandom_range('h10000, 'h10FFFF)) :
                                  u2u_pkg::POINT_W'($urandom_range(0, 'h1FFFFF));
                endcase
                // now and then cut the sequence short
                send_point(cp, len, ($urandom_range(0, 9) == 0) ?
                           $urandom_range(1, len - 1) : len);
            end else begin
                send_byte(u2u_pkg::BYTE_W'($urandom_range(0, 255)));
            end
        end
        send_byte(NUL_BYTE);
    endtask

    // ------------------------------------------------------------------
    // Result side: pacing and checking
    // ------------------------------------------------------------------

    initial begin
        int gap;
        forever begin
            // long hold-off so the block fills and stalls its input
            if (long_hold_req) begin
                m_ready <= 1'b0;
                for (int n = 0; n < LONG_HOLD; n++) @(posedge aclk);
                long_hold_req = 1'b0;
            end
            gap = rx_gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && !s_ready)
                input_stall_cycles++;
            if (m_valid && m_ready) begin
                got_unit = {m_code_unit, m_string_end, m_run_last};
                if (expected_units.size() == 0) begin
                    $display("%0t: unit %h with nothing expected", $time, got_unit.code_unit);
                    mismatches++;
                end else begin
                    want_unit = expected_units.pop_front();
                    units_checked++;
                    if (got_unit.code_unit !== want_unit.code_unit) begin
                        $display("%0t: code_unit expected %h actual %h",
                                 $time, want_unit.code_unit, got_unit.code_unit);
                        mismatches++;
                    end
                    if (got_unit.string_end !== want_unit.string_end) begin
                        $display("%0t: string_end expected %b actual %b",
                                 $time, want_unit.string_end, got_unit.string_end);
                        mismatches++;
                    end
                    if (got_unit.run_last !== want_unit.run_last) begin
                        $display("%0t: run_last expected %b actual %b",
                                 $time, want_unit.run_last, got_unit.run_last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        for (watch_cycles = 0; watch_cycles < RUN_LIMIT; watch_cycles++)
            @(posedge aclk);
        $display("%0t: run limit reached, %0d units outstanding",
                 $time, expected_units.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // ASCII extremes and well-formed two, three and four byte sequences
    task automatic test_plain_and_multibyte();
        send_byte(8'h01);
        send_byte(8'h7F);
        send_point(21'h0000A9, 2, 2);
        send_point(21'h0020AC, 3, 3);
        send_point(21'h01F600, 4, 4);
        send_point(u2u_pkg::MAX_POINT, 4, 4);
        send_byte(NUL_BYTE);
    endtask

    // Overlong zero, surrogate, out of range, stray bytes, broken sequences
    task automatic test_malformed();
        send_point(21'h000000, 2, 2);
        send_point(u2u_pkg::SURR_FIRST, 3, 3);
        send_point(21'h110000, 4, 4);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'hE2);
        send_byte(8'h41);
        // zero byte in the middle of a sequence
        send_point(21'h0020AC, 3, 2);
        send_byte(NUL_BYTE);
    endtask

    // Full destination, pair that will not fit, capacity of one and of zero
    task automatic test_capacity_limits();
        set_capacity(13'd3);
        send_byte(8'h41);
        send_byte(8'h42);
        send_byte(8'h43);
        send_byte(8'h44);
        send_byte(NUL_BYTE);
        send_byte(8'h41);
        send_point(21'h01F600, 4, 4);
        send_byte(NUL_BYTE);
        set_capacity(13'd4);
        send_point(21'h01F600, 4, 4);
        send_byte(8'h41);
        send_byte(8'h42);
        send_byte(NUL_BYTE);
        set_capacity(13'd1);
        send_byte(8'h41);
        send_byte(NUL_BYTE);
        set_capacity(13'd0);
        send_point(21'h0000A9, 2, 2);
        send_byte(NUL_BYTE);
    endtask

    // Capacity lowered to the units already written, then raised mid-string
    task automatic test_capacity_change();
        set_capacity(13'd10);
        send_byte(8'h41);
        send_byte(8'h42);
        send_byte(8'h43);
        send_byte(8'h44);
        set_capacity(13'd4);
        send_byte(8'h45);
        send_byte(8'h46);
        send_byte(NUL_BYTE);
        set_capacity(13'd3);
        send_byte(8'h41);
        send_byte(8'h42);
        set_capacity(13'd8);
        send_byte(8'h43);
        send_byte(NUL_BYTE);
    endtask

    // Hold the result side while bytes keep coming
    task automatic test_backpressure();
        set_capacity(13'd4096);
        tx_gaps_on    = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 16; i++) begin
            if (i % 4 == 3)
                send_point(21'h010000 + u2u_pkg::POINT_W'(i), 4, 4);
            else
                send_byte(8'h61 + u2u_pkg::BYTE_W'(i));
        end
        send_byte(NUL_BYTE);
        tx_gaps_on = 1'b1;
    endtask

    // Random strings across several capacities
    task automatic test_random_strings();
        logic [u2u_pkg::CAP_W-1:0] caps [RANDOM_PHASES];
        int                        goal;
        caps = '{13'd1, 13'd2, 13'd0, u2u_pkg::CAP_W'($urandom_range(5, 24)),
                 13'd65, 13'd4096, 13'd8191};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_capacity(caps[p]);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            goal = sent_bytes + PHASE_BYTES;
            while (sent_bytes < goal)
                send_random_string();
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_data_byte <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_plain_and_multibyte();
        test_malformed();
        test_capacity_limits();
        test_capacity_change();
        test_backpressure();
        test_random_strings();
        wait_idle();

        $display("Sent %0d bytes (%0d decoded) in %0d strings: %0d units checked, %0d pairs.",
                 sent_bytes, live_bytes, strings_done, units_checked, pairs_seen);
        $display("Capacity written %0d times; input held back for %0d cycles.",
                 cap_writes, input_stall_cycles);
        if (mismatches == 0 && expected_units.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
